### design/icfd_pkg.sv
package icfd_pkg;

    // Frame constants
    localparam logic [3:0] FRAME_LEN   = 4'd8;
    localparam logic [7:0] HEADER_BYTE = 8'h55;

    // Register indexes on the configuration port
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_STALE_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_GAP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_TIME     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_ACCEL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_GYRO     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_ANGLE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_MAGN     = 3'd6;
    localparam int unsigned CFG_DATA_W = 16;

    // Register reset values
    localparam logic [15:0] RST_STALE_TIMEOUT = 16'd500;
    localparam logic [7:0]  RST_ANGLE_GAP     = 8'd50;
    localparam logic [7:0]  RST_CODE_TIME     = 8'd80;
    localparam logic [7:0]  RST_CODE_ACCEL    = 8'd81;
    localparam logic [7:0]  RST_CODE_GYRO     = 8'd82;
    localparam logic [7:0]  RST_CODE_ANGLE    = 8'd83;
    localparam logic [7:0]  RST_CODE_MAGN     = 8'd84;

    // Result status codes
    localparam logic [3:0] ST_BAD_LEN   = 4'd0;
    localparam logic [3:0] ST_BAD_HDR   = 4'd1;
    localparam logic [3:0] ST_BAD_TYPE  = 4'd2;
    localparam logic [3:0] ST_BAD_AXIS  = 4'd3;
    localparam logic [3:0] ST_TIME      = 4'd4;
    localparam logic [3:0] ST_ACCEL     = 4'd5;
    localparam logic [3:0] ST_GYRO      = 4'd6;
    localparam logic [3:0] ST_ANGLE     = 4'd7;
    localparam logic [3:0] ST_MAGN      = 4'd8;
    localparam logic [3:0] ST_TICK      = 4'd9;

    // Angle axis codes
    localparam logic [7:0] AXIS_ROLL  = 8'd1;
    localparam logic [7:0] AXIS_PITCH = 8'd2;
    localparam logic [7:0] AXIS_YAW   = 8'd3;

    // Bits of the seen flags
    localparam int unsigned SEEN_ACCEL = 0;
    localparam int unsigned SEEN_GYRO  = 1;
    localparam int unsigned SEEN_ANGLE = 2;
    localparam int unsigned SEEN_MAGN  = 3;

    // Queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    // Class of a beat as decided by the front
    typedef enum logic [3:0] {
        K_BAD_LEN  = 4'd0,
        K_BAD_HDR  = 4'd1,
        K_BAD_TYPE = 4'd2,
        K_TIME     = 4'd4,
        K_ACCEL    = 4'd5,
        K_GYRO     = 4'd6,
        K_ANGLE    = 4'd7,
        K_MAGN     = 4'd8,
        K_TICK     = 4'd9
    } kind_t;

    typedef struct packed {
        logic [0:0] operation;
        logic [3:0] frame_length;
        logic [7:0] byte_0;
        logic [7:0] byte_1;
        logic [7:0] byte_2;
        logic [7:0] byte_3;
        logic [7:0] byte_4;
        logic [7:0] byte_5;
        logic [7:0] byte_6;
        logic [7:0] byte_7;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         status;
        logic signed [15:0] x_raw;
        logic signed [15:0] y_raw;
        logic signed [15:0] z_raw;
        logic signed [31:0] angle_value;
        logic [1:0]         angle_axis;
        logic [47:0]        time_stamp;
        logic               accel_ok;
        logic               gyro_ok;
        logic               angle_ok;
        logic               magn_ok;
    } out_item_t;

    // Queue entry: class and payload bytes 2..7, byte 2 at the top
    typedef struct packed {
        kind_t       kind;
        logic [47:0] data;
    } q_entry_t;

    typedef struct packed {
        logic [15:0] stale_timeout_ms;
        logic [7:0]  angle_gap_ms;
        logic [7:0]  code_time;
        logic [7:0]  code_accel;
        logic [7:0]  code_gyro;
        logic [7:0]  code_angle;
        logic [7:0]  code_magn;
    } cfg_t;

endpackage

### design/icfd_front.sv
module icfd_front
    import icfd_pkg::*;
(
    input  in_item_t item,
    input  cfg_t     cfg,
    output q_entry_t entry
);

    kind_t kind;

    // Tick beats first, then length, header and type; equal codes resolve time first
    always_comb begin
        if (item.operation == 1'b1) begin
            kind = K_TICK;
        end else if (item.frame_length != FRAME_LEN) begin
            kind = K_BAD_LEN;
        end else if (item.byte_0 != HEADER_BYTE) begin
            kind = K_BAD_HDR;
        end else if (item.byte_1 == cfg.code_time) begin
            kind = K_TIME;
        end else if (item.byte_1 == cfg.code_accel) begin
            kind = K_ACCEL;
        end else if (item.byte_1 == cfg.code_gyro) begin
            kind = K_GYRO;
        end else if (item.byte_1 == cfg.code_angle) begin
            kind = K_ANGLE;
        end else if (item.byte_1 == cfg.code_magn) begin
            kind = K_MAGN;
        end else begin
            kind = K_BAD_TYPE;
        end
    end

    assign entry.kind = kind;
    assign entry.data = {item.byte_2, item.byte_3, item.byte_4,
                         item.byte_5, item.byte_6, item.byte_7};

endmodule

### design/icfd_queue.sv
module icfd_queue
    import icfd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     push,
    input  q_entry_t push_entry,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output q_entry_t head_entry
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

    q_entry_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == DEPTH_CNT);
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### design/icfd_back.sv
module icfd_back
    import icfd_pkg::*;
#(
    parameter int AGE_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      head_valid,
    input  q_entry_t  head_entry,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int unsigned CMP_W = (AGE_BITS > 16) ? AGE_BITS : 16;

    logic [AGE_BITS-1:0] accel_age_reg, accel_age_next;
    logic [AGE_BITS-1:0] gyro_age_reg,  gyro_age_next;
    logic [AGE_BITS-1:0] magn_age_reg,  magn_age_next;
    logic [AGE_BITS-1:0] angle_age_reg, angle_age_next;
    logic [3:0]          seen_reg,      seen_next;
    logic                angle_seen_reg, angle_seen_next;
    logic [2:0]          axis_ready_reg, axis_ready_next;
    logic                m_valid_reg;
    out_item_t           out_reg, out_next;

    logic [7:0]       b2, b3, b4, b5, b6, b7;
    logic [2:0]       axis_set;
    logic [CMP_W-1:0] timeout_w, gap_w;
    logic [CMP_W-1:0] accel_w, gyro_w, magn_w, angle_w, angle_now_w;

    assign pop     = head_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    assign {b2, b3, b4, b5, b6, b7} = head_entry.data;

    assign timeout_w   = CMP_W'(cfg.stale_timeout_ms);
    assign gap_w       = CMP_W'(cfg.angle_gap_ms);
    assign angle_now_w = CMP_W'(angle_age_reg);

    function automatic logic [AGE_BITS-1:0] age_inc(input logic [AGE_BITS-1:0] a);
        age_inc = (a == '1) ? a : a + 1'b1;
    endfunction

    // State update for the beat at the head of the queue
    always_comb begin
        accel_age_next  = accel_age_reg;
        gyro_age_next   = gyro_age_reg;
        magn_age_next   = magn_age_reg;
        angle_age_next  = angle_age_reg;
        seen_next       = seen_reg;
        angle_seen_next = angle_seen_reg;
        axis_ready_next = axis_ready_reg;
        axis_set        = axis_ready_reg;

        out_next            = '0;
        out_next.status     = ST_BAD_LEN;

        unique case (head_entry.kind) inside
            K_TICK: begin
                out_next.status = ST_TICK;
                accel_age_next  = age_inc(accel_age_reg);
                gyro_age_next   = age_inc(gyro_age_reg);
                magn_age_next   = age_inc(magn_age_reg);
                angle_age_next  = age_inc(angle_age_reg);
            end
            K_BAD_LEN: out_next.status = ST_BAD_LEN;
            K_BAD_HDR: out_next.status = ST_BAD_HDR;
            K_BAD_TYPE: out_next.status = ST_BAD_TYPE;
            K_TIME: begin
                out_next.status     = ST_TIME;
                out_next.time_stamp = head_entry.data;
            end
            K_ACCEL, K_GYRO, K_MAGN: begin
                out_next.x_raw = {b3, b2};
                out_next.y_raw = {b5, b4};
                out_next.z_raw = {b7, b6};
                if (head_entry.kind == K_ACCEL) begin
                    out_next.status       = ST_ACCEL;
                    seen_next[SEEN_ACCEL] = 1'b1;
                    accel_age_next        = '0;
                end else if (head_entry.kind == K_GYRO) begin
                    out_next.status      = ST_GYRO;
                    seen_next[SEEN_GYRO] = 1'b1;
                    gyro_age_next        = '0;
                end else begin
                    out_next.status      = ST_MAGN;
                    seen_next[SEEN_MAGN] = 1'b1;
                    magn_age_next        = '0;
                end
            end
            K_ANGLE: begin
                // No earlier angle beat, or too long since the last one: drop the partial set
                if (!angle_seen_reg || (angle_now_w > gap_w)) begin
                    axis_set              = '0;
                    seen_next[SEEN_ANGLE] = 1'b0;
                end
                axis_ready_next = axis_set;
                angle_seen_next = 1'b1;
                angle_age_next  = '0;
                if ((b2 == AXIS_ROLL) || (b2 == AXIS_PITCH) || (b2 == AXIS_YAW)) begin
                    out_next.status      = ST_ANGLE;
                    out_next.angle_axis  = b2[1:0];
                    out_next.angle_value = {b7, b6, b5, b4};
                    axis_set[b2[1:0] - 2'd1] = 1'b1;
                    if (axis_set == 3'b111) begin
                        seen_next[SEEN_ANGLE] = 1'b1;
                        axis_ready_next       = '0;
                    end else begin
                        axis_ready_next = axis_set;
                    end
                end else begin
                    out_next.status = ST_BAD_AXIS;
                end
            end
            default: out_next.status = ST_BAD_LEN;
        endcase

        accel_w = CMP_W'(accel_age_next);
        gyro_w  = CMP_W'(gyro_age_next);
        magn_w  = CMP_W'(magn_age_next);
        angle_w = CMP_W'(angle_age_next);

        out_next.accel_ok = seen_next[SEEN_ACCEL] && (accel_w <= timeout_w);
        out_next.gyro_ok  = seen_next[SEEN_GYRO]  && (gyro_w  <= timeout_w);
        out_next.angle_ok = seen_next[SEEN_ANGLE] && (angle_w <= timeout_w);
        out_next.magn_ok  = seen_next[SEEN_MAGN]  && (magn_w  <= timeout_w);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accel_age_reg  <= '0;
            gyro_age_reg   <= '0;
            magn_age_reg   <= '0;
            angle_age_reg  <= '0;
            seen_reg       <= '0;
            angle_seen_reg <= 1'b0;
            axis_ready_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (pop) begin
                accel_age_reg  <= accel_age_next;
                gyro_age_reg   <= gyro_age_next;
                magn_age_reg   <= magn_age_next;
                angle_age_reg  <= angle_age_next;
                seen_reg       <= seen_next;
                angle_seen_reg <= angle_seen_next;
                axis_ready_reg <= axis_ready_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= out_next;
        end
    end

endmodule

### design/imu_can_frame_decoder.sv
// IMU CAN frame decoder. Each input beat is either an 8-byte sensor CAN
// frame or a 1 ms tick, and each gives exactly one result beat: a status
// code, the decoded time stamp, x/y/z values or one axis angle, and four
// ok flags (accel, gyro, angle set, magn) that say the quantity has been
// seen and its age is within stale_timeout_ms. Throughput is one beat per
// cycle while m_ready is high; an accepted input beat is written into the
// two-entry queue and then into the output register, and its result is
// held back while m_ready is low. The back end sets the throughput: it
// updates the age and flag state once per beat.
// Configuration is taken through cfg_wr_en/cfg_index/cfg_data and must
// only be written while the block is idle; indexes beyond the register
// list are ignored.
module imu_can_frame_decoder
    import icfd_pkg::*;
#(
    parameter int AGE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input beats
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_item,
    // Result beats
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_item
);

    cfg_t     cfg_reg;
    q_entry_t front_entry;
    q_entry_t head_entry;
    logic     q_full;
    logic     head_valid;
    logic     pop;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stale_timeout_ms <= RST_STALE_TIMEOUT;
            cfg_reg.angle_gap_ms     <= RST_ANGLE_GAP;
            cfg_reg.code_time        <= RST_CODE_TIME;
            cfg_reg.code_accel       <= RST_CODE_ACCEL;
            cfg_reg.code_gyro        <= RST_CODE_GYRO;
            cfg_reg.code_angle       <= RST_CODE_ANGLE;
            cfg_reg.code_magn        <= RST_CODE_MAGN;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_STALE_TIMEOUT: cfg_reg.stale_timeout_ms <= cfg_data;
                CFG_ANGLE_GAP:     cfg_reg.angle_gap_ms     <= cfg_data[7:0];
                CFG_CODE_TIME:     cfg_reg.code_time        <= cfg_data[7:0];
                CFG_CODE_ACCEL:    cfg_reg.code_accel       <= cfg_data[7:0];
                CFG_CODE_GYRO:     cfg_reg.code_gyro        <= cfg_data[7:0];
                CFG_CODE_ANGLE:    cfg_reg.code_angle       <= cfg_data[7:0];
                CFG_CODE_MAGN:     cfg_reg.code_magn        <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Front: classify the beat as it arrives
    icfd_front u_front (
        .item  (s_item),
        .cfg   (cfg_reg),
        .entry (front_entry)
    );

    // Accept whenever the queue has room, regardless of the result side
    assign s_ready = !q_full;

    icfd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_valid),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // Back: state update and registered result
    icfd_back #(
        .AGE_BITS (AGE_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule
